// File: design/acav_pkg.sv
// ============================================================================
// acav_pkg - shared definitions for the auto-ranging current averager
// Field widths, register codes, parameter defaults and the result beat type.
// ============================================================================
`default_nettype none

package acav_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int SAMPLE_FIELD_W = 10;
    localparam int RANGE_W        = 2;
    localparam int AVG_W          = 10;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 24;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 10;

    // Parameter defaults
    localparam int BLOCK_SAMPLES_DEF = 20;
    localparam int WINDOW_TAPS_DEF   = 10;
    localparam int NUM_RANGES_DEF    = 4;
    localparam int SAMPLE_BITS_DEF   = 10;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] WINDOW_LOW_RST  = 10'd205;
    localparam logic [CFG_DATA_W-1:0] WINDOW_HIGH_RST = 10'd696;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_LOW  = 2'd0,
        REG_WINDOW_HIGH = 2'd1
    } cfg_reg_t;

    typedef logic [RANGE_W-1:0] range_t;
    typedef logic [AVG_W-1:0]   avg_t;

    typedef struct packed {
        avg_t   block_average;
        range_t range_used;
        logic   done_res;
        range_t next_range;
    } result_t;

endpackage

`default_nettype wire

// File: design/autorange_current_averager.sv
// ============================================================================
// autorange_current_averager - auto-ranging ADC block and moving averager
// Block-averages samples per amplifier range, steps the range until the
// average falls inside the window or the last range is reached, and keeps a
// moving average of accepted block averages.
// ============================================================================
// One ADC sample is taken per beat and every sample yields exactly one result
// beat, one sample per clock sustained while m_axis_tready does not stall. The
// first stage updates the block sum, range select and the window running sum;
// the second divides the running sum by WINDOW_TAPS into the output register.
// The per-cycle limit is the block-sum add, the divide-by-BLOCK_SAMPLES
// multiply, the window compare and the running-sum update in the state loop.
// The user must write limits only while the stream is idle; it is not enforced.
`default_nettype none

module autorange_current_averager #(
    parameter int BLOCK_SAMPLES = acav_pkg::BLOCK_SAMPLES_DEF,
    parameter int WINDOW_TAPS   = acav_pkg::WINDOW_TAPS_DEF,
    parameter int NUM_RANGES    = acav_pkg::NUM_RANGES_DEF,
    parameter int SAMPLE_BITS   = acav_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input stream
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    input  wire logic [acav_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [9:0] sample
    // Result stream
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [1:0] next_range, [3:2] range_used, [13:4] block_average,
    // [23:14] current_average
    output      logic [acav_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output      logic                              m_axis_tuser,  // [0] done_res
    // Configuration writes
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [acav_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [acav_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int USE_BITS = (SAMPLE_BITS < acav_pkg::SAMPLE_FIELD_W) ?
                              SAMPLE_BITS : acav_pkg::SAMPLE_FIELD_W;
    localparam int SUM_W    = $clog2((2**USE_BITS - 1) * BLOCK_SAMPLES + 1);
    localparam int WS_W     = $clog2((2**USE_BITS - 1) * WINDOW_TAPS + 1);
    localparam int CNT_W    = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam int PTR_W    = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1;

    // Configuration
    logic [acav_pkg::CFG_DATA_W-1:0] window_low_reg,  window_low_next;
    logic [acav_pkg::CFG_DATA_W-1:0] window_high_reg, window_high_next;

    // Measurement state
    acav_pkg::range_t     amp_reg,   amp_next;
    logic [CNT_W-1:0]     cnt_reg,   cnt_next;
    logic [SUM_W-1:0]     sum_reg,   sum_next;
    logic [PTR_W-1:0]     ptr_reg,   ptr_next;
    logic [WS_W-1:0]      wsum_reg,  wsum_next;
    logic [USE_BITS-1:0]  window_reg [WINDOW_TAPS];

    // Pipeline
    logic                 s1_valid_reg, s1_valid_next;
    acav_pkg::result_t    s1_reg,       s1_next;
    logic                 out_valid_reg, out_valid_next;
    acav_pkg::result_t    out_reg,      out_next;
    acav_pkg::avg_t       cur_avg_reg,  cur_avg_next;

    logic                 accept;
    logic                 out_free;
    logic                 s1_move;
    logic [USE_BITS-1:0]  sample;
    logic [SUM_W-1:0]     sum_new;
    logic [USE_BITS-1:0]  blk_q;
    logic [USE_BITS-1:0]  win_q;
    acav_pkg::avg_t       blk_avg;
    logic                 block_end;
    logic                 in_window;
    logic                 last_range;
    logic                 take;

    acav_cdiv #(
        .IN_W    (SUM_W),
        .OUT_W   (USE_BITS),
        .DIVISOR (BLOCK_SAMPLES)
    ) u_blk_div (
        .dividend (sum_new),
        .quotient (blk_q)
    );

    acav_cdiv #(
        .IN_W    (WS_W),
        .OUT_W   (USE_BITS),
        .DIVISOR (WINDOW_TAPS)
    ) u_win_div (
        .dividend (wsum_reg),
        .quotient (win_q)
    );

    // Handshakes: stage 1 holds only while the output register is stalled
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_move       = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        window_low_next  = window_low_reg;
        window_high_next = window_high_reg;
        if (cfg_valid)
        begin
            unique case (acav_pkg::cfg_reg_t'(cfg_index))
                acav_pkg::REG_WINDOW_LOW:  window_low_next  = cfg_data;
                acav_pkg::REG_WINDOW_HIGH: window_high_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        sample     = s_axis_tdata[USE_BITS-1:0];
        sum_new    = sum_reg + SUM_W'(sample);
        blk_avg    = acav_pkg::AVG_W'(blk_q);
        block_end  = (cnt_reg == CNT_W'(BLOCK_SAMPLES - 1));
        in_window  = (blk_avg > window_low_reg) && (blk_avg < window_high_reg);
        last_range = (amp_reg >= acav_pkg::RANGE_W'(NUM_RANGES - 1));
        take       = block_end && (in_window || last_range);

        amp_next  = amp_reg;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        ptr_next  = ptr_reg;
        wsum_next = wsum_reg;
        s1_next   = s1_reg;

        if (accept)
        begin
            cnt_next = block_end ? '0 : cnt_reg + CNT_W'(1);
            sum_next = block_end ? '0 : sum_new;
            if (take)
            begin
                amp_next  = '0;
                wsum_next = wsum_reg - WS_W'(window_reg[ptr_reg]) + WS_W'(blk_q);
                ptr_next  = (ptr_reg == PTR_W'(WINDOW_TAPS - 1)) ? '0
                                                                 : ptr_reg + PTR_W'(1);
            end
            else if (block_end)
            begin
                amp_next = amp_reg + 2'd1;
            end
            s1_next.next_range    = amp_next;
            s1_next.done_res      = take;
            s1_next.range_used    = take ? amp_reg : '0;
            s1_next.block_average = take ? blk_avg : '0;
        end
    end

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
        out_next       = out_reg;
        cur_avg_next   = cur_avg_reg;
        // Running sum already holds this beat's push; later beats wait behind it
        if (s1_move)
        begin
            out_next     = s1_reg;
            cur_avg_next = acav_pkg::AVG_W'(win_q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg  <= acav_pkg::WINDOW_LOW_RST;
            window_high_reg <= acav_pkg::WINDOW_HIGH_RST;
            amp_reg         <= '0;
            cnt_reg         <= '0;
            sum_reg         <= '0;
            ptr_reg         <= '0;
            wsum_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < WINDOW_TAPS; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            window_low_reg  <= window_low_next;
            window_high_reg <= window_high_next;
            amp_reg         <= amp_next;
            cnt_reg         <= cnt_next;
            sum_reg         <= sum_next;
            ptr_reg         <= ptr_next;
            wsum_reg        <= wsum_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            if (accept && take)
            begin
                window_reg[ptr_reg] <= blk_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= s1_next;
        out_reg     <= out_next;
        cur_avg_reg <= cur_avg_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.done_res;
    assign m_axis_tdata  = {cur_avg_reg, out_reg.block_average,
                            out_reg.range_used, out_reg.next_range};

endmodule

`default_nettype wire

// File: design/acav_cdiv.sv
// ============================================================================
// acav_cdiv - unsigned divide by a constant
// Floor quotient by reciprocal multiply and shift; exact for all IN_W-bit
// inputs (reciprocal rounded up, IN_W+1 bits wide).
// ============================================================================
`default_nettype none

module acav_cdiv #(
    parameter int IN_W    = 15,
    parameter int OUT_W   = 10,
    parameter int DIVISOR = 20
) (
    input  wire logic [IN_W-1:0]  dividend,
    output      logic [OUT_W-1:0] quotient
);

    localparam int LOG_D = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
    localparam int SHIFT = IN_W + LOG_D;
    localparam int M_W   = IN_W + 1;
    localparam int P_W   = IN_W + M_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [M_W-1:0] RECIP = RECIP_L[M_W-1:0];

    logic [P_W-1:0] product;
    logic [P_W-1:0] shifted;

    always_comb
    begin
        product  = P_W'(dividend) * P_W'(RECIP);
        shifted  = product >> SHIFT;
        quotient = shifted[OUT_W-1:0];
    end

endmodule

`default_nettype wire
